>>> hw/rtl/colpk_pkg.sv
`default_nettype none

package colpk_pkg;

	// Orbit arithmetic and field widths
	localparam int VALUE_W    = 64;
	localparam int START_W    = 32;
	localparam int LIMIT_W    = 16;
	localparam int COUNT_W    = 16;
	localparam int STEP_WIDTH = 16;

	// Common width for comparing the register against the counter capacity
	localparam int LIM_EXT_W  = (STEP_WIDTH > LIMIT_W) ? STEP_WIDTH : LIMIT_W;
	localparam int CNT_EXT_W  = (STEP_WIDTH > COUNT_W) ? STEP_WIDTH : COUNT_W;

	// Largest x for which 3x+1 still fits in VALUE_W bits
	localparam logic [VALUE_W-1:0] TRIPLE_MAX = 64'h5555_5555_5555_5554;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_LIMIT    = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} colpk_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic terminal;
	} colpk_stat_t;

	// Limit in force: smaller of the register and the counter capacity
	function automatic logic [STEP_WIDTH-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
		logic [LIM_EXT_W-1:0] lim_ext;
		logic [LIM_EXT_W-1:0] cap_ext;
		logic [LIM_EXT_W-1:0] sel;
		lim_ext = LIM_EXT_W'(lim);
		cap_ext = LIM_EXT_W'({STEP_WIDTH{1'b1}});
		sel = (lim_ext < cap_ext) ? lim_ext : cap_ext;
		return sel[STEP_WIDTH-1:0];
	endfunction

	// Counter value as the reported step count field
	function automatic logic [COUNT_W-1:0] to_count(input logic [STEP_WIDTH-1:0] steps);
		logic [CNT_EXT_W-1:0] ext;
		ext = CNT_EXT_W'(steps);
		return ext[COUNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/colpk_ctrl.sv
`default_nettype none

module colpk_ctrl
	import colpk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire logic        out_stall,
	input  wire colpk_stat_t stat,
	output colpk_cmd_t       cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	// Output slot can take a result when empty or being drained now
	assign slot_free = !out_valid_q || !out_stall;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				if (stat.terminal) begin
					if (slot_free) begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/colpk_dpath.sv
`default_nettype none

module colpk_dpath
	import colpk_pkg::*;
(
	input  wire logic                  clk,
	input  wire colpk_cmd_t            cmd,
	input  wire logic [START_W-1:0]    start_value,
	input  wire logic                  last_in_range,
	input  wire logic [STEP_WIDTH-1:0] limit,
	output colpk_stat_t                stat,
	output logic [COUNT_W-1:0]         step_count,
	output logic [VALUE_W-1:0]         peak_value,
	output logic [1:0]                 status,
	output logic                       last_out
);

	logic [VALUE_W-1:0]    x_q, peak_q, triple, x_next;
	logic [STEP_WIDTH-1:0] steps_q;
	logic                  last_q;

	logic [COUNT_W-1:0]    count_out_q;
	logic [VALUE_W-1:0]    peak_out_q;
	status_t               status_out_q;
	logic                  last_out_q;

	logic    is_zero, is_one, lim_hit, ovf, odd;
	status_t fin_status;

	// One map application: 3x+1 as 2x + x + 1, or a halving
	assign odd    = x_q[0];
	assign triple = {x_q[VALUE_W-2:0], 1'b0} + x_q + VALUE_W'(1);
	assign x_next = odd ? triple : {1'b0, x_q[VALUE_W-1:1]};

	// End tests in priority order: zero, reached one, limit, overflow
	assign is_zero = (x_q == '0);
	assign is_one  = (x_q == VALUE_W'(1));
	assign lim_hit = (steps_q >= limit);
	assign ovf     = odd && (x_q > TRIPLE_MAX);

	always_comb begin
		if (is_zero)
			fin_status = ST_ZERO;
		else if (is_one)
			fin_status = ST_OK;
		else if (lim_hit)
			fin_status = ST_LIMIT;
		else
			fin_status = ST_OVERFLOW;
	end

	assign stat.terminal = is_zero || is_one || lim_hit || ovf;

	// Orbit registers; a halving never raises the peak
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= VALUE_W'(start_value);
			peak_q  <= VALUE_W'(start_value);
			steps_q <= '0;
			last_q  <= last_in_range;
		end else if (cmd.step) begin
			x_q     <= x_next;
			steps_q <= steps_q + STEP_WIDTH'(1);
			if (odd && (triple > peak_q))
				peak_q <= triple;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			count_out_q  <= to_count(steps_q);
			peak_out_q   <= peak_q;
			status_out_q <= fin_status;
			last_out_q   <= last_q;
		end
	end

	assign step_count = count_out_q;
	assign peak_value = peak_out_q;
	assign status     = status_out_q;
	assign last_out   = last_out_q;

endmodule

`default_nettype wire

>>> hw/rtl/collatz_orbit_length_peak_unit.sv
`default_nettype none

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   start_value[31:0], last_in_range
// out      output     out_valid / out_stall step_count[15:0], peak_value[63:0],
//                                           status[1:0], last_out
// cfg      input      cfg_valid / cfg_ready cfg_data[15:0] (step_limit)
//
// The orbit register applies one map step per cycle while an orbit runs.
// The input is stalled while an orbit runs; a finished result waits in the
// output register, so the next item is taken while it is still held.
// Reset clears control state; step_limit resets to 65535. No clearing pass.

module collatz_orbit_length_peak_unit
	import colpk_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [START_W-1:0] start_value,
	input  wire logic               last_in_range,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [COUNT_W-1:0]      step_count,
	output logic [VALUE_W-1:0]      peak_value,
	output logic [1:0]              status,
	output logic                    last_out,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [LIMIT_W-1:0] cfg_data
);

	logic [LIMIT_W-1:0] step_limit_q;
	colpk_cmd_t         cmd;
	colpk_stat_t        stat;

	// Step limit register, always ready for a write request
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_limit_q <= LIMIT_RESET;
		else if (cfg_valid && cfg_ready)
			step_limit_q <= cfg_data;
	end

	colpk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	colpk_dpath u_dpath (
		.clk           (clk),
		.cmd           (cmd),
		.start_value   (start_value),
		.last_in_range (last_in_range),
		.limit         (eff_limit(step_limit_q)),
		.stat          (stat),
		.step_count    (step_count),
		.peak_value    (peak_value),
		.status        (status),
		.last_out      (last_out)
	);

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import colpk_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int MAX_REPORTS     = 10;
	localparam int CHUNK_ITEMS     = 40;
	localparam int NUM_CHUNKS      = 15;
	localparam int LONG_HOLD       = 3000;
	localparam int DIR_ROWS        = 22;

	// One orbit result as the block reports it
	typedef struct {
		logic [COUNT_W-1:0] steps;
		logic [VALUE_W-1:0] peak;
		status_t            st;
		logic               last;
	} orbit_t;

	// Directed row: optional limit write, the request, and a hand-typed result if typed
	typedef struct {
		int                 lim;
		logic [START_W-1:0] k;
		logic               last;
		bit                 typed;
		logic [COUNT_W-1:0] steps;
		logic [VALUE_W-1:0] peak;
		status_t            st;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [START_W-1:0] start_value;
	logic               last_in_range;
	logic               out_valid;
	logic               out_stall;
	logic [COUNT_W-1:0] step_count;
	logic [VALUE_W-1:0] peak_value;
	logic [1:0]         status;
	logic               last_out;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data;

	orbit_t             pending_orbits[$];
	logic [LIMIT_W-1:0] limit_reg;
	int                 snd_idle_pct;
	int                 rcv_idle_pct;
	int                 hold_left;
	int                 mismatches;
	int                 quiet_cycles;
	int                 results_seen;
	int                 sent_in_chunk;
	dir_row_t           dir_table [DIR_ROWS];

	always #4 clk = ~clk;

	collatz_orbit_length_peak_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_value   (start_value),
		.last_in_range (last_in_range),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.step_count    (step_count),
		.peak_value    (peak_value),
		.status        (status),
		.last_out      (last_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Walk the orbit of k under the given step limit register
	function automatic orbit_t collatz_orbit(input logic [START_W-1:0] k, input logic last,
			input logic [LIMIT_W-1:0] lim_reg);
		orbit_t      r;
		logic [63:0] x;
		logic [63:0] cap;
		logic [63:0] lim;
		logic [63:0] n;
		cap = (64'd1 << STEP_WIDTH) - 64'd1;
		lim = (64'(lim_reg) < cap) ? 64'(lim_reg) : cap;
		x = 64'(k);
		n = 64'd0;
		r.peak = x;
		r.st = ST_OK;
		r.last = last;
		if (x == 64'd0) begin
			r.st = ST_ZERO;
		end else begin
			while (x != 64'd1) begin
				// limit check wins over the overflow check
				if (n >= lim) begin
					r.st = ST_LIMIT;
					break;
				end
				if (x[0]) begin
					if (x > TRIPLE_MAX) begin
						r.st = ST_OVERFLOW;
						break;
					end
					x = x * 64'd3 + 64'd1;
				end else begin
					x = x >> 1;
				end
				if (x > r.peak)
					r.peak = x;
				n = n + 64'd1;
			end
		end
		r.steps = n[COUNT_W-1:0];
		return r;
	endfunction

	// Mix of start values: full range, small, powers of two, near the top
	function automatic logic [START_W-1:0] draw_start();
		case ($urandom_range(0, 5))
			0: return START_W'($urandom_range(0, 3000));
			1: return 32'd1 << $urandom_range(0, 31);
			2: return 32'hFFFF_FFFF - START_W'($urandom_range(0, 64));
			3: return START_W'($urandom_range(0, 3));
			default: return START_W'($urandom);
		endcase
	endfunction

	// Append an expected result at the tail of the scoreboard
	task automatic queue_expected(input orbit_t r);
		pending_orbits.insert(pending_orbits.size(), r);
	endtask

	// Offer one request; valid stays up from the previous one if no gap is drawn
	task automatic offer_request(input logic [START_W-1:0] k, input logic last,
			input bit typed, input orbit_t typed_res);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		start_value   <= k;
		last_in_range <= last;
		do @(posedge clk); while (in_stall);
		if (typed)
			queue_expected(typed_res);
		else
			queue_expected(collatz_orbit(k, last, limit_reg));
		sent_in_chunk++;
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain_requests();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_orbits.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		limit_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stall, or a long hold-off counted here
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		orbit_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_orbits.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d with no request outstanding: %s%0d %s%h %s%0d %s%b",
						results_seen, "steps=", step_count, "peak=", peak_value,
						"st=", status, "last=", last_out);
			end else begin
				want = pending_orbits.pop_front();
				if (step_count !== want.steps || peak_value !== want.peak ||
						status !== want.st || last_out !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("result %0d: expected steps=%0d peak=%h st=%0d last=%b,",
							results_seen, want.steps, want.peak, want.st, want.last);
						$display("    got steps=%0d peak=%h st=%0d last=%b",
							step_count, peak_value, status, last_out);
					end
				end
			end
		end
	end

	// Watchdog: cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES - 1) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		orbit_t             typed_res;
		orbit_t             no_res;
		logic [START_W-1:0] base;
		logic [LIMIT_W-1:0] lim;
		int                 len;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		start_value   = '0;
		last_in_range = 1'b0;
		out_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		limit_reg     = LIMIT_RESET;
		snd_idle_pct  = 6;
		rcv_idle_pct  = 50;
		hold_left     = 0;
		mismatches    = 0;
		quiet_cycles  = 0;
		results_seen  = 0;
		sent_in_chunk = 0;
		no_res        = '{steps: '0, peak: '0, st: ST_OK, last: 1'b0};

		// lim -1 keeps the current step limit
		dir_table = '{
			'{-1,    32'd1,           1'b0, 1'b1, 16'd0,   64'd1,           ST_OK},
			'{-1,    32'd0,           1'b0, 1'b1, 16'd0,   64'd0,           ST_ZERO},
			'{-1,    32'd2,           1'b0, 1'b1, 16'd1,   64'd2,           ST_OK},
			'{-1,    32'd3,           1'b0, 1'b1, 16'd7,   64'd16,          ST_OK},
			'{-1,    32'd27,          1'b0, 1'b1, 16'd111, 64'd9232,        ST_OK},
			'{-1,    32'hFFFF_FFFF,   1'b0, 1'b0, 16'd0,   64'd0,           ST_OK},
			'{-1,    32'h8000_0000,   1'b1, 1'b1, 16'd31,  64'h8000_0000,   ST_OK},
			'{-1,    32'hFFFF_FFFE,   1'b1, 1'b0, 16'd0,   64'd0,           ST_OK},
			'{-1,    32'd7,           1'b1, 1'b1, 16'd16,  64'd52,          ST_OK},
			// limit of zero: nothing but zero and one finishes
			'{0,     32'd5,           1'b0, 1'b1, 16'd0,   64'd5,           ST_LIMIT},
			'{-1,    32'd1,           1'b0, 1'b1, 16'd0,   64'd1,           ST_OK},
			'{-1,    32'd0,           1'b1, 1'b1, 16'd0,   64'd0,           ST_ZERO},
			'{-1,    32'hFFFF_FFFF,   1'b0, 1'b1, 16'd0,   64'hFFFF_FFFF,   ST_LIMIT},
			// limit of one
			'{1,     32'd2,           1'b0, 1'b1, 16'd1,   64'd2,           ST_OK},
			'{-1,    32'd3,           1'b0, 1'b1, 16'd1,   64'd10,          ST_LIMIT},
			'{-1,    32'd4,           1'b1, 1'b1, 16'd1,   64'd4,           ST_LIMIT},
			// orbit of 7 needs exactly 16 steps
			'{16,    32'd7,           1'b0, 1'b1, 16'd16,  64'd52,          ST_OK},
			'{-1,    32'd9,           1'b0, 1'b0, 16'd0,   64'd0,           ST_OK},
			'{15,    32'd7,           1'b1, 1'b1, 16'd15,  64'd52,          ST_LIMIT},
			'{65535, 32'd837799,      1'b0, 1'b0, 16'd0,   64'd0,           ST_OK},
			'{-1,    32'hAAAA_AAAA,   1'b1, 1'b0, 16'd0,   64'd0,           ST_OK},
			'{-1,    32'h5555_5555,   1'b0, 1'b0, 16'd0,   64'd0,           ST_OK}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		foreach (dir_table[i]) begin
			if (dir_table[i].lim >= 0) begin
				drain_requests();
				write_limit(LIMIT_W'(dir_table[i].lim));
			end
			typed_res = '{steps: dir_table[i].steps, peak: dir_table[i].peak,
				st: dir_table[i].st, last: dir_table[i].last};
			offer_request(dir_table[i].k, dir_table[i].last, dir_table[i].typed, typed_res);
		end

		// Random chunks, each under a fresh limit written while idle
		for (int c = 0; c < NUM_CHUNKS; c++) begin
			if (c < 5) begin
				snd_idle_pct = 6;
				rcv_idle_pct = 50;
			end else if (c < 10) begin
				snd_idle_pct = 50;
				rcv_idle_pct = 6;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			case ($urandom_range(0, 9))
				0: lim = '0;
				1: lim = LIMIT_W'(1);
				2, 3: lim = LIMIT_W'($urandom_range(2, 400));
				4: lim = LIMIT_W'($urandom_range(401, 65534));
				default: lim = LIMIT_RESET;
			endcase
			drain_requests();
			write_limit(lim);
			// back-pressure: receiver holds off while the sender keeps offering
			if (c == 11)
				hold_left = LONG_HOLD;
			sent_in_chunk = 0;
			while (sent_in_chunk < CHUNK_ITEMS) begin
				if ($urandom_range(0, 4) != 0) begin
					// well-formed range k..k+len-1 with the final one marked
					base = draw_start();
					len = $urandom_range(1, 8);
					for (int j = 0; j < len; j++)
						offer_request(base + START_W'(j), (j == len - 1), 1'b0, no_res);
				end else begin
					offer_request(draw_start(), 1'($urandom_range(0, 1)), 1'b0, no_res);
				end
			end
		end

		drain_requests();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
